### rtl/dtwl_pkg.sv
// Shared types and constants for the DDS tuning word loader.
// Used by every module under rtl; depends on nothing else.
package dtwl_pkg;

	localparam int unsigned FREQ_BITS  = 32;
	localparam int unsigned FRAME_BITS = 16;
	localparam int unsigned HALF_BITS  = 14;
	localparam int unsigned TW_BITS    = 2 * HALF_BITS;

	// Frequency register select bits placed above each tuning word half
	localparam logic [FRAME_BITS-1:0] FREQ_REG_PREFIX = 16'h4000;

	typedef struct packed {
		logic [FREQ_BITS-1:0] target_freq;
		logic [FREQ_BITS-1:0] ref_clock;
	} in_word_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic                  last_frame;
	} out_word_t;

endpackage

### rtl/dtwl_div.sv
// Bit-serial restoring divider: (freq << P) / ref, one quotient bit per cycle.
// Depends on dtwl_pkg for the operand width.
module dtwl_div import dtwl_pkg::*; #(
	parameter int unsigned P = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FREQ_BITS-1:0] freq,
	input  logic [FREQ_BITS-1:0] divisor,
	output logic                 done,
	output logic [P-1:0]         quotient
);

	localparam int unsigned STEPS = FREQ_BITS + P;
	localparam int unsigned CNT_W = $clog2(STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FREQ_BITS-1:0] dvd_q;
	logic [FREQ_BITS-1:0] rem_q;
	logic [FREQ_BITS-1:0] div_q;
	logic [P-1:0]         quo_q;

	logic [FREQ_BITS:0]   trial;
	logic [FREQ_BITS+1:0] diff;
	logic                 ge;
	logic [FREQ_BITS-1:0] rem_next;

	// Bring down the next dividend bit and try the subtraction
	assign trial    = {rem_q, dvd_q[FREQ_BITS-1]};
	assign diff     = {1'b0, trial} - {2'b00, div_q};
	assign ge       = ~diff[FREQ_BITS+1];
	assign rem_next = ge ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];

	// Control: count the shift steps up to STEPS, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out MSB first, zeros follow the frequency bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= freq;
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FREQ_BITS-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[P-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("done without a finished run");

endmodule

### rtl/dds_tuning_word_loader.sv
// Top level of the DDS tuning word loader: change detect, divider, frame output.
// Depends on dtwl_pkg and dtwl_div.
//
// Usage:
//  An input word carries target_freq and ref_clock. It is taken when in_valid
//  is high and in_stall low. If the pair equals the last pair taken (both zero
//  after reset), nothing is emitted. Otherwise the block computes
//  tw = floor(target_freq * 2^PHASE_ACC_BITS / ref_clock) mod 2^PHASE_ACC_BITS
//  with a bit-serial divider (one quotient bit per cycle) and
//  then sends two output words: 0x4000 | tw[13:0] with last_frame low, then
//  0x4000 | tw[27:14] with last_frame high. A zero ref_clock gives tw all ones.
//  An item that changes the pair occupies the block through the divide and both
//  frame loads; an unchanged pair is taken while the block stays idle.
//  in_stall stays high until the second frame sits in the output register.
//  When out_stall is high and a word is valid, the output word holds and the block waits for it.
//  Reset clears the stored pair and drops any pending output.
module dds_tuning_word_loader import dtwl_pkg::*; #(
	parameter int unsigned PHASE_ACC_BITS = 28
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_F0   = 2'd2;
	localparam logic [1:0] ST_F1   = 2'd3;

	logic [1:0]           state_q;
	logic [FREQ_BITS-1:0] prev_freq_q;
	logic [FREQ_BITS-1:0] prev_ref_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic                      in_take;
	logic                      changed;
	logic                      div_start;
	logic                      div_done;
	logic [PHASE_ACC_BITS-1:0] quo;
	logic [TW_BITS-1:0]        tw;
	logic                      out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign changed   = (in_word.target_freq != prev_freq_q) ||
	                   (in_word.ref_clock != prev_ref_q);
	assign div_start = in_take && changed;
	assign out_free  = !out_valid_q || !out_stall;

	dtwl_div #(
		.P(PHASE_ACC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.freq     (in_word.target_freq),
		.divisor  (in_word.ref_clock),
		.done     (div_done),
		.quotient (quo)
	);

	// Fit the quotient to the 28 bits the two frames carry
	for (genvar i = 0; i < TW_BITS; i++) begin : g_tw
		if (i < PHASE_ACC_BITS) begin : g_bit
			assign tw[i] = quo[i];
		end else begin : g_zero
			assign tw[i] = 1'b0;
		end
	end

	// Sequence: idle, divide, load low frame, load high frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_freq_q <= '0;
			prev_ref_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						prev_freq_q <= in_word.target_freq;
						prev_ref_q  <= in_word.ref_clock;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_F0;
					end
				end
				ST_F0: begin
					if (out_free) begin
						state_q <= ST_F1;
					end
				end
				ST_F1: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: drop the word when taken, load the next frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_F0 || state_q == ST_F1) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_F0 && out_free) begin
			out_q.frame      <= FREQ_REG_PREFIX | {2'b00, tw[HALF_BITS-1:0]};
			out_q.last_frame <= 1'b0;
		end else if (state_q == ST_F1 && out_free) begin
			out_q.frame      <= FREQ_REG_PREFIX | {2'b00, tw[TW_BITS-1:HALF_BITS]};
			out_q.last_frame <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider finished outside divide");
	a_low_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F1 |-> out_valid_q && !out_q.last_frame)
		else $error("low frame missing before high frame");
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.frame[FRAME_BITS-1:FRAME_BITS-2] == 2'b01)
		else $error("frame prefix wrong");
	a_start_store: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> prev_freq_q == $past(in_word.target_freq) &&
		prev_ref_q == $past(in_word.ref_clock)) else $error("pair not stored");

endmodule
